/* rtl/cfe_pkg.sv */
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared constants and types of the COBS frame encoder: group and word
// sizes, group store addressing, and the command passed from front to back.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int unsigned OutBytes  = 8;
  localparam int unsigned WordBytes = (OutBytes > 8) ? 8 : OutBytes;
  localparam int unsigned WordW     = 64;
  localparam int unsigned CntW      = 4;
  localparam int unsigned SlotW     = $clog2(WordBytes);

  localparam int unsigned GroupMax  = 254;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned Banks     = 2;
  localparam int unsigned BankW     = $clog2(Banks);
  localparam int unsigned RamAw     = BankW + IdxW;
  localparam int unsigned RamDepth  = Banks * (2 ** IdxW);

  // Longest run: code, full group, empty group code, delimiter.
  localparam int unsigned PosW      = 9;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CodeEmpty = 8'h01;

  // One closed group plus what follows it in the same run.
  typedef struct packed {
    logic [BankW-1:0] bank;
    logic [IdxW-1:0]  len;         // bytes in the group, 0 to GroupMax
    logic             tail_empty;  // empty group follows (code 0x01)
    logic             eom;         // delimiter closes the run
  } cmd_t;

  // Back tells front that a bank has been read out.
  typedef struct packed {
    logic             valid;
    logic [BankW-1:0] bank;
  } rel_t;

endpackage

/* rtl/cfe_ram.sv */
// ----------------------------------------------------------------------------
// cfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cfe_front.sv */
// ----------------------------------------------------------------------------
// cfe_front
// Accepts input items, stores group bytes in the current bank and pushes a
// command whenever an item closes a group.
// ----------------------------------------------------------------------------
module cfe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [7:0]                   delimiter_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         byte_present_i,
  input  logic                         end_of_message_i,
  output logic                         ram_we_o,
  output logic [cfe_pkg::RamAw-1:0]    ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic                         push_o,
  output cfe_pkg::cmd_t                cmd_o,
  input  logic                         q_ready_i,
  input  cfe_pkg::rel_t                rel_i,
  output logic [cfe_pkg::Banks-1:0]    busy_o
);

  logic [cfe_pkg::IdxW-1:0]  len_q, len_d;
  logic [cfe_pkg::BankW-1:0] bank_q, bank_d;
  logic [cfe_pkg::Banks-1:0] busy_q, busy_d;

  logic                      accept;
  logic                      is_delim;
  logic                      append;
  logic [cfe_pkg::IdxW-1:0]  grown;
  logic                      full;
  logic                      close_now;

  assign in_stall_o = busy_q[bank_q] || !q_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_delim  = (data_byte_i == delimiter_i);
  assign append    = byte_present_i && !is_delim;
  assign grown     = append ? (len_q + 1'b1) : len_q;
  assign full      = (grown == cfe_pkg::IdxW'(cfe_pkg::GroupMax));
  assign close_now = byte_present_i && (is_delim || full);

  assign ram_we_o    = accept && append;
  assign ram_waddr_o = {bank_q, len_q};
  assign ram_wdata_o = data_byte_i;

  assign push_o         = accept && (close_now || end_of_message_i);
  assign cmd_o.bank       = bank_q;
  assign cmd_o.len        = grown;
  assign cmd_o.tail_empty = close_now && end_of_message_i;
  assign cmd_o.eom        = end_of_message_i;

  always_comb begin
    len_d  = len_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (push_o) begin
        // Hand the bank to the back end and fill the other one.
        busy_d[bank_q] = 1'b1;
        len_d          = '0;
        bank_d         = bank_q + 1'b1;
      end else begin
        len_d = grown;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      bank_q <= '0;
      busy_q <= '0;
    end else begin
      len_q  <= len_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

/* rtl/cfe_queue.sv */
// ----------------------------------------------------------------------------
// cfe_queue
// Short FIFO of group commands between front and back.
// ----------------------------------------------------------------------------
module cfe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfe_pkg::cmd_t cmd_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cfe_pkg::cmd_t cmd_o
);

  cfe_pkg::cmd_t               slot_q [cfe_pkg::QueueDepth];
  logic [cfe_pkg::QPtrW-1:0]   wr_q, rd_q;
  logic [cfe_pkg::QCntW-1:0]   cnt_q;
  logic                        do_push, do_pop;

  assign ready_o = (cnt_q != cfe_pkg::QCntW'(cfe_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];

  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/cfe_back.sv */
// ----------------------------------------------------------------------------
// cfe_back
// Walks one command byte by byte (code, group bytes from the store, empty
// group code, delimiter), packs the bytes into words and holds each word
// in an output register.
// ----------------------------------------------------------------------------
module cfe_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [7:0]                delimiter_i,
  input  logic                      q_valid_i,
  input  cfe_pkg::cmd_t             q_cmd_i,
  output logic                      pop_o,
  output logic                      ram_re_o,
  output logic [cfe_pkg::RamAw-1:0] ram_raddr_o,
  input  logic [7:0]                ram_rdata_i,
  output cfe_pkg::rel_t             rel_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cfe_pkg::WordW-1:0] packed_bytes_o,
  output logic [cfe_pkg::CntW-1:0]  byte_count_o,
  output logic                      run_last_o,
  output logic                      frame_end_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  // Sequencer stage
  logic                      state_q, state_d;
  cfe_pkg::cmd_t             cmd_q;
  logic [cfe_pkg::PosW-1:0]  pos_q;
  logic [cfe_pkg::PosW-1:0]  last_pos_q;
  logic                      adv;
  logic                      at_last;
  logic                      from_ram;
  logic [7:0]                const_byte;
  logic [cfe_pkg::PosW-1:0]  len_ext;

  // Byte stage
  logic                      b_vld_q;
  logic                      b_ram_q;
  logic [7:0]                b_byte_q;
  logic                      b_last_q;
  logic                      b_eom_q;
  logic [7:0]                cur_byte;
  logic                      b_ok;
  logic                      consume;
  logic                      complete;

  // Word assembly
  logic [7:0]                asm_q [cfe_pkg::WordBytes];
  logic [cfe_pkg::SlotW-1:0] slot_q;
  logic [cfe_pkg::CntW-1:0]  fill;
  logic [cfe_pkg::WordW-1:0] word;

  // Output register
  logic                      o_vld_q;
  logic [cfe_pkg::WordW-1:0] o_word_q;
  logic [cfe_pkg::CntW-1:0]  o_cnt_q;
  logic                      o_last_q;
  logic                      o_fe_q;
  logic                      o_free;

  assign len_ext = {1'b0, cmd_q.len};
  assign at_last = (pos_q == last_pos_q);

  // Sort the current position into code, stored byte or trailer.
  always_comb begin
    from_ram   = 1'b0;
    const_byte = delimiter_i;
    if (pos_q == '0) begin
      const_byte = cmd_q.len + 1'b1;
    end else if (pos_q <= len_ext) begin
      from_ram = 1'b1;
    end else if (cmd_q.tail_empty && (pos_q == len_ext + 1'b1)) begin
      const_byte = cfe_pkg::CodeEmpty;
    end
  end

  assign cur_byte = b_ram_q ? ram_rdata_i : b_byte_q;
  assign fill     = {1'b0, slot_q} + 1'b1;
  assign complete = (fill == cfe_pkg::CntW'(cfe_pkg::WordBytes)) || b_last_q;
  assign o_free   = !o_vld_q || !out_stall_i;
  assign b_ok     = !b_vld_q || !complete || o_free;
  assign consume  = b_vld_q && (!complete || o_free);

  assign adv    = (state_q == StRun) && b_ok;
  assign pop_o  = (state_q == StIdle) && q_valid_i;

  assign ram_re_o    = adv && from_ram;
  assign ram_raddr_o = {cmd_q.bank, cfe_pkg::IdxW'(pos_q - 1'b1)};

  assign rel_o.valid = adv && at_last;
  assign rel_o.bank  = cmd_q.bank;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (adv && at_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Merge the incoming byte into the partial word.
  always_comb begin
    for (int j = 0; j < cfe_pkg::WordBytes; j++) begin
      if (j < int'(slot_q)) begin
        word[8*j +: 8] = asm_q[j];
      end else if (j == int'(slot_q)) begin
        word[8*j +: 8] = cur_byte;
      end else begin
        word[8*j +: 8] = '0;
      end
    end
    for (int j = cfe_pkg::WordBytes; j < 8; j++) begin
      word[8*j +: 8] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q      <= q_cmd_i;
      last_pos_q <= cfe_pkg::PosW'(q_cmd_i.len) + cfe_pkg::PosW'(q_cmd_i.tail_empty)
                    + cfe_pkg::PosW'(q_cmd_i.eom);
    end
    if (adv) begin
      b_ram_q  <= from_ram;
      b_byte_q <= const_byte;
      b_last_q <= at_last;
      b_eom_q  <= cmd_q.eom;
    end
    if (consume && !complete) begin
      asm_q[slot_q] <= cur_byte;
    end
    if (consume && complete) begin
      o_word_q <= word;
      o_cnt_q  <= fill;
      o_last_q <= b_last_q;
      o_fe_q   <= b_last_q && b_eom_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      b_vld_q <= 1'b0;
      slot_q  <= '0;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        pos_q <= '0;
      end else if (adv) begin
        pos_q <= pos_q + 1'b1;
      end
      if (adv) begin
        b_vld_q <= 1'b1;
      end else if (consume) begin
        b_vld_q <= 1'b0;
      end
      if (consume) begin
        slot_q <= complete ? '0 : cfe_pkg::SlotW'(fill);
      end
      if (consume && complete) begin
        o_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = o_vld_q;
  assign packed_bytes_o = o_word_q;
  assign byte_count_o   = o_cnt_q;
  assign run_last_o     = o_last_q;
  assign frame_end_o    = o_fe_q;

endmodule

/* rtl/cobs_frame_encoder.sv */
// ----------------------------------------------------------------------------
// cobs_frame_encoder
// Streaming COBS encoder with a programmable delimiter byte; encoded bytes
// leave packed eight to a word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one item per handshake with an
//   optional message byte and an end-of-message mark. Items that only add a
//   byte to the open group are taken one per cycle unless in_stall_o is high.
//   An item that closes a group hands the filled bank of the group store to
//   the back end and the front continues in the other bank at once.
//   Output channel (out_valid_o / out_stall_i): a closed group is read out
//   at one byte per cycle while not stalled, over the store's single read
//   port; a run of L bytes, code and trailer included, leaves as ceil(L/8)
//   words; run_last_o marks a run's last word, frame_end_o the delimiter's.
//   The front stalls only when the bank it would fill is still being read.
//   Configuration (cfg_valid_i / cfg_ready_o): writes the delimiter; write
//   it only while no run is in flight.
//   Reset clears the open group, the bank flags, the queue and the delimiter
//   (to zero). A stalled receiver holds the output word; the back end then
//   backs up, and the front keeps taking items until its bank is needed.
// ----------------------------------------------------------------------------
module cobs_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] packed_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        run_last_o,
  output logic        frame_end_o
);

  logic [7:0]                   delim_q;

  logic                         ram_we;
  logic [cfe_pkg::RamAw-1:0]    ram_waddr;
  logic [7:0]                   ram_wdata;
  logic                         ram_re;
  logic [cfe_pkg::RamAw-1:0]    ram_raddr;
  logic [7:0]                   ram_rdata;

  logic                         push;
  cfe_pkg::cmd_t                push_cmd;
  logic                         q_ready;
  logic                         pop;
  logic                         q_valid;
  cfe_pkg::cmd_t                q_cmd;
  cfe_pkg::rel_t                rel;
  logic [cfe_pkg::Banks-1:0]    busy;

  // Delimiter register: always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      delim_q <= cfg_data_i;
    end
  end

  // Classify items and fill the group store.
  cfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .delimiter_i      (delim_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .q_ready_i        (q_ready),
    .rel_i            (rel),
    .busy_o           (busy)
  );

  // Two banks of group bytes.
  cfe_ram #(
    .Width (8),
    .Depth (cfe_pkg::RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Closed groups waiting for the back end.
  cfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Emit code, bytes and trailer, packed into words.
  cfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .delimiter_i    (delim_q),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .pop_o          (pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .rel_o          (rel),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_bytes_o (packed_bytes_o),
    .byte_count_o   (byte_count_o),
    .run_last_o     (run_last_o),
    .frame_end_o    (frame_end_o)
  );

  // The delimiter is always the final byte of a run.
  a_fe_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o)
    else $error("frame end on a word that does not close the run");

  // A word carries one to eight bytes.
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o != 4'd0) && (byte_count_o <= 4'd8))
    else $error("byte count out of range");

  // Only a bank that was handed over can be released.
  a_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel.valid |-> busy[rel.bank])
    else $error("release of a bank that is not in use");

  // A new command never targets a bank still being read.
  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !busy[push_cmd.bank])
    else $error("group closed into a busy bank");

endmodule

/* sim/tb_cobs_frame_encoder.sv */
// ----------------------------------------------------------------------------
// tb_cobs_frame_encoder
// Self-checking bench for the COBS frame encoder. An in-bench encoder
// predicts the packed words for every accepted item, and a monitor checks
// each word taken from the output channel against the oldest prediction.
// Directed items, a full 254-byte group, a long receiver hold-off and
// randomized message traffic run under changing delimiters and idling.
// ----------------------------------------------------------------------------
module tb_cobs_frame_encoder;

  localparam int unsigned StuckLimit   = 5000;  // cycles with no handshake at all
  localparam int unsigned SettleCycles = 16;    // quiet time before a delimiter write
  localparam int unsigned TailCycles   = 300;   // longest run plus margin
  localparam int unsigned HoldCycles   = 400;   // long receiver hold-off
  localparam int unsigned MaxReports   = 10;

  typedef struct {
    logic [cfe_pkg::WordW-1:0] bytes;
    logic [cfe_pkg::CntW-1:0]  cnt;
    logic                      last;
    logic                      fe;
  } enc_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] packed_bytes_o;
  logic [3:0]  byte_count_o;
  logic        run_last_o;
  logic        frame_end_o;

  // Encoder state as the bench sees it.
  logic [7:0]  enc_delim;
  logic [7:0]  open_group[$];
  logic [7:0]  run_bytes[$];
  enc_word_t   pending_words[$];

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned words_seen;
  int unsigned fail_count;
  int unsigned stuck_cycles;

  cobs_frame_encoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .packed_bytes_o   (packed_bytes_o),
    .byte_count_o     (byte_count_o),
    .run_last_o       (run_last_o),
    .frame_end_o      (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Emit the open group as code byte plus its bytes, then empty it.
  function automatic void close_open_group();
    logic [7:0] code;
    code = 8'(open_group.size() + 1);
    run_bytes.push_back(code);
    foreach (open_group[i]) run_bytes.push_back(open_group[i]);
    open_group.delete();
  endfunction

  // Encode one accepted item and queue the words it produces.
  function automatic void encode_item(logic [7:0] d, logic p, logic e);
    int unsigned n_words;
    int unsigned base;
    int unsigned cnt;
    enc_word_t   w;
    run_bytes.delete();
    if (p) begin
      if (d == enc_delim) begin
        close_open_group();
      end else begin
        if (open_group.size() < cfe_pkg::GroupMax) open_group.push_back(d);
        // A group that reaches the limit closes on its own with code 0xFF.
        if (open_group.size() >= cfe_pkg::GroupMax) close_open_group();
      end
    end
    if (e) begin
      // The open group closes even when empty, then the delimiter follows.
      close_open_group();
      run_bytes.push_back(enc_delim);
    end
    n_words = (run_bytes.size() + cfe_pkg::WordBytes - 1) / cfe_pkg::WordBytes;
    for (int k = 0; k < n_words; k++) begin
      base = k * cfe_pkg::WordBytes;
      cnt  = run_bytes.size() - base;
      if (cnt > cfe_pkg::WordBytes) cnt = cfe_pkg::WordBytes;
      w.bytes = '0;
      for (int j = 0; j < cnt; j++) w.bytes[8*j +: 8] = run_bytes[base + j];
      w.cnt  = cnt[cfe_pkg::CntW-1:0];
      w.last = (k + 1 == n_words);
      w.fe   = e && (k + 1 == n_words);
      pending_words.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Offer one item at a falling edge after a random gap, hold it until it is
  // taken, and predict its words at the accepting edge. Valid stays high on
  // return so back-to-back items need no gap; end_input lowers it.
  task automatic send_item(input logic [7:0] d, input logic p, input logic e);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    data_byte_i      = d;
    byte_present_i   = p;
    end_of_message_i = e;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    encode_item(d, p, e);
  endtask

  task automatic end_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Stop offering, wait for every predicted word, then let the block settle.
  task automatic drain(input int unsigned quiet);
    end_input();
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (quiet) @(posedge clk_i);
  endtask

  // Write the delimiter only with nothing in flight.
  task automatic write_delimiter(input logic [7:0] v);
    drain(SettleCycles);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    enc_delim = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver: a pending hold-off wins, otherwise stall at random.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected word: bytes=%h count=%0d last=%b end=%b",
                   packed_bytes_o, byte_count_o, run_last_o, frame_end_o);
      end else begin
        enc_word_t w;
        w = pending_words.pop_front();
        if (packed_bytes_o !== w.bytes || byte_count_o !== w.cnt ||
            run_last_o !== w.last || frame_end_o !== w.fe) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("mismatch word %0d: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                     words_seen, w.bytes, w.cnt, w.last, w.fe,
                     packed_bytes_o, byte_count_o, run_last_o, frame_end_o);
        end
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long.
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < StuckLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", StuckLimit);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset delimiter zero: bare end, idle item, delimiter byte, byte extremes.
  task automatic test_reset_delimiter();
    send_item(8'h5A, 1'b0, 1'b1);  // empty frame: 01 00
    send_item(8'hC3, 1'b0, 1'b0);  // idle item, no result
    send_item(8'h00, 1'b1, 1'b0);  // delimiter closes an empty group
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);  // delimiter together with message end
    send_item(8'hAA, 1'b1, 1'b1);  // byte together with message end
  endtask

  // A delimiter at the top of the byte range, one in the middle and one that collides with codes.
  task automatic test_high_delimiter();
    write_delimiter(8'hFF);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    write_delimiter(8'h80);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h81, 1'b1, 1'b1);
    write_delimiter(8'h03);
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b1);  // code byte 03 equals the delimiter
  endtask

  // Send n bytes that are never the delimiter.
  task automatic send_plain_bytes(input int unsigned n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom); while (b == enc_delim);
      send_item(b, 1'b1, 1'b0);
    end
  endtask

  // A group that fills up closes with 0xFF; the message end on the byte that
  // fills it adds an empty group before the delimiter.
  task automatic test_full_group();
    logic [7:0] b;
    send_plain_bytes(cfe_pkg::GroupMax - 1);
    do b = 8'($urandom); while (b == enc_delim);
    send_item(b, 1'b1, 1'b1);      // longest run: 33 words
  endtask

  // Hold the receiver off while short frames keep arriving until the front
  // runs out of banks and stalls its input.
  task automatic test_output_holdoff();
    int unsigned saved_snd;
    saved_snd = snd_idle_pct;
    snd_idle_pct = 0;
    hold_left = HoldCycles;
    for (int i = 0; i < 4; i++) begin
      send_item(8'($urandom), 1'b1, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b1);
    end
    drain(SettleCycles);
    snd_idle_pct = saved_snd;
  endtask

  // Mostly complete messages with random content, some stray bytes and idle
  // items. Idle items do not count toward n_items.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    logic [7:0]  b;
    logic        eom_on_byte;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end else if (kind == 1) begin
        send_item(8'($urandom), 1'b1, 1'($urandom));
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        eom_on_byte = 1'($urandom);
        for (int i = 0; i < len; i++) begin
          b = ($urandom_range(0, 5) == 0) ? enc_delim : 8'($urandom);
          send_item(b, 1'b1, eom_on_byte && (i == len - 1));
          sent++;
        end
        if (!eom_on_byte || len == 0) begin
          send_item(8'($urandom), 1'b0, 1'b1);
          sent++;
        end
      end
    end
    // Close whatever is still open so the next setting starts clean.
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Three settings: sender light and receiver heavy, swapped, then none.
  task automatic test_random_traffic();
    write_delimiter(8'($urandom_range(1, 254)));
    run_random_phase(20);
    snd_idle_pct = 67;
    rcv_idle_pct = 25;
    write_delimiter(8'hFF);
    run_random_phase(20);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_delimiter(8'h00);
    run_random_phase(20);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = 8'h00;
    in_valid_i       = 1'b0;
    data_byte_i      = 8'h00;
    byte_present_i   = 1'b0;
    end_of_message_i = 1'b0;
    enc_delim        = 8'h00;
    snd_idle_pct     = 25;
    rcv_idle_pct     = 67;
    hold_left        = 0;
    items_sent       = 0;
    words_seen       = 0;
    fail_count       = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_delimiter();
    test_high_delimiter();
    test_full_group();
    test_output_holdoff();
    test_random_traffic();
    drain(TailCycles);

    // Anything still predicted here never came out.
    fail_count += pending_words.size();
    $display("covered %0d items and %0d words: delimiters 00, FF, 80, 03 and random,",
             items_sent, words_seen);
    $display("a full 254-byte group, a %0d-cycle output hold-off, three idling mixes",
             HoldCycles);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failing words", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* cobs_frame_encoder.f */
rtl/cfe_pkg.sv
rtl/cfe_ram.sv
rtl/cfe_front.sv
rtl/cfe_queue.sv
rtl/cfe_back.sv
rtl/cobs_frame_encoder.sv
sim/tb_cobs_frame_encoder.sv
